@@ rtl/sha1_stream_hash_assert.svh @@
// assertion macros shared by the checker of the sha-1 stream hasher
// depends on nothing; the including file supplies the clock and reset names
`ifndef SHA1_STREAM_HASH_ASSERT_SVH
`define SHA1_STREAM_HASH_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define SHA1S_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define SHA1S_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sha1s_pkg.sv @@
// types and constants of the sha-1 stream hasher
// used by the controller, the datapath, the top level and the checker
package sha1s_pkg;

    // one input transfer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } in_item_t;

    // one result transfer
    typedef struct packed {
        logic [31:0] digest_h0;
        logic [31:0] digest_h1;
        logic [31:0] digest_h2;
        logic [31:0] digest_h3;
        logic [31:0] digest_h4;
        logic [63:0] message_bits;
    } out_item_t;

    // how the block words are formed for one compression
    typedef logic [1:0] blk_mode_t;
    localparam blk_mode_t MODE_NORMAL = 2'd0; // full buffered block
    localparam blk_mode_t MODE_PAD1   = 2'd1; // tail, 0x80, zeros, length
    localparam blk_mode_t MODE_PAD2A  = 2'd2; // tail, 0x80, zeros
    localparam blk_mode_t MODE_PAD2B  = 2'd3; // zeros, length

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;

    // controller to datapath commands
    typedef struct packed {
        logic       byte_wr;
        logic       round_en;
        logic [6:0] round_idx;
        blk_mode_t  mode;
        logic       chain_add;
        logic       finish;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [5:0] fill;
    } dp_stat_t;

    // initial chaining values
    localparam logic [31:0] IV_H0 = 32'h67452301;
    localparam logic [31:0] IV_H1 = 32'hefcdab89;
    localparam logic [31:0] IV_H2 = 32'h98badcfe;
    localparam logic [31:0] IV_H3 = 32'h10325476;
    localparam logic [31:0] IV_H4 = 32'hc3d2e1f0;

    // round constants
    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

@@ rtl/sha1s_ctrl.sv @@
// controller of the sha-1 stream hasher: input handshake, round sequencing, result valid
// depends on sha1s_pkg
module sha1s_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sha1s_pkg::in_item_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sha1s_pkg::dp_cmd_t  cmd,
    input  sha1s_pkg::dp_stat_t stat
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PAD_SEL = 3'd1;
    localparam logic [2:0] ST_ROUND   = 3'd2;
    localparam logic [2:0] ST_ADD     = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [6:0]           round_reg, round_next;
    sha1s_pkg::blk_mode_t mode_reg, mode_next;
    logic                 last_pend_reg, last_pend_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 s_xfer;
    logic                 out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        mode_next      = mode_reg;
        last_pend_next = last_pend_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        cmd           = '0;
        cmd.byte_wr   = s_xfer && s_data.byte_present;
        cmd.round_idx = round_reg;
        cmd.mode      = mode_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_data.byte_present && stat.fill == sha1s_pkg::FILL_LAST) begin
                        // this byte completes a block
                        state_next     = ST_ROUND;
                        mode_next      = sha1s_pkg::MODE_NORMAL;
                        round_next     = '0;
                        last_pend_next = s_data.last;
                    end else if (s_data.last) begin
                        state_next = ST_PAD_SEL;
                    end
                end
            end
            ST_PAD_SEL: begin
                // one padding block if the length still fits, else two
                mode_next  = (stat.fill < sha1s_pkg::LEN_START) ?
                             sha1s_pkg::MODE_PAD1 : sha1s_pkg::MODE_PAD2A;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (round_reg == sha1s_pkg::ROUND_LAST) begin
                    round_next = '0;
                    state_next = ST_ADD;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_ADD: begin
                cmd.chain_add = 1'b1;
                case (mode_reg)
                    sha1s_pkg::MODE_NORMAL: begin
                        state_next     = last_pend_reg ? ST_PAD_SEL : ST_IDLE;
                        last_pend_next = 1'b0;
                    end
                    sha1s_pkg::MODE_PAD2A: begin
                        mode_next  = sha1s_pkg::MODE_PAD2B;
                        state_next = ST_ROUND;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_FINISH: begin
                // wait for the result register to be free
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            mode_reg      <= sha1s_pkg::MODE_NORMAL;
            last_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            mode_reg      <= mode_next;
            last_pend_reg <= last_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

endmodule

@@ rtl/sha1s_dp.sv @@
// datapath of the sha-1 stream hasher: block buffer, schedule window, round unit,
// chaining words, bit counter and result register; depends on sha1s_pkg
module sha1s_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           data_byte,
    input  sha1s_pkg::dp_cmd_t   cmd,
    output sha1s_pkg::dp_stat_t  stat,
    output sha1s_pkg::out_item_t m_data
);

    localparam logic [6:0] T_MSG_END = 7'd16;
    localparam logic [6:0] T_F1      = 7'd20;
    localparam logic [6:0] T_F2      = 7'd40;
    localparam logic [6:0] T_F3      = 7'd60;
    localparam logic [3:0] W_LEN_HI  = 4'd14;
    localparam logic [3:0] W_LEN_LO  = 4'd15;

    logic [31:0]          blk_word_reg [16];
    logic [31:0]          win_reg [16];
    logic [31:0]          chain_reg [5];
    logic [31:0]          var_reg [5];
    logic [5:0]           fill_reg;
    logic [63:0]          bits_reg;
    sha1s_pkg::out_item_t out_reg;

    logic [31:0] a_cur, b_cur, c_cur, d_cur, e_cur;
    logic [31:0] raw_word, msg_word, sched_word, w_cur;
    logic [31:0] f_cur, k_cur, tmp_cur;
    logic [4:0]  lane_off;

    assign stat.fill = fill_reg;
    assign m_data    = out_reg;
    assign lane_off  = {~fill_reg[1:0], 3'b000};

    // working variables come from the chaining words in the first round
    always_comb begin
        if (cmd.round_idx == '0) begin
            a_cur = chain_reg[0];
            b_cur = chain_reg[1];
            c_cur = chain_reg[2];
            d_cur = chain_reg[3];
            e_cur = chain_reg[4];
        end else begin
            a_cur = var_reg[0];
            b_cur = var_reg[1];
            c_cur = var_reg[2];
            d_cur = var_reg[3];
            e_cur = var_reg[4];
        end
    end

    // message word: buffered bytes, padding byte, zeros or length halves
    always_comb begin
        logic [5:0] pos;
        logic       keep_tail;
        pos       = '0;
        raw_word  = blk_word_reg[cmd.round_idx[3:0]];
        keep_tail = (cmd.mode != sha1s_pkg::MODE_PAD2B);
        msg_word  = raw_word;
        if (cmd.mode != sha1s_pkg::MODE_NORMAL) begin
            for (int j = 0; j < 4; j++) begin
                pos = {cmd.round_idx[3:0], 2'(j)};
                if (keep_tail && pos < fill_reg) begin
                    msg_word[8*(3-j) +: 8] = raw_word[8*(3-j) +: 8];
                end else if (keep_tail && pos == fill_reg) begin
                    msg_word[8*(3-j) +: 8] = sha1s_pkg::PAD_BYTE;
                end else begin
                    msg_word[8*(3-j) +: 8] = 8'h00;
                end
            end
            if (cmd.mode == sha1s_pkg::MODE_PAD1 || cmd.mode == sha1s_pkg::MODE_PAD2B) begin
                if (cmd.round_idx[3:0] == W_LEN_HI) begin
                    msg_word = bits_reg[63:32];
                end else if (cmd.round_idx[3:0] == W_LEN_LO) begin
                    msg_word = bits_reg[31:0];
                end
            end
        end
    end

    // schedule expansion from the window taps t-3, t-8, t-14, t-16
    always_comb begin
        logic [31:0] mix;
        mix        = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        sched_word = {mix[30:0], mix[31]};
        w_cur      = (cmd.round_idx < T_MSG_END) ? msg_word : sched_word;
    end

    // round function and constant
    always_comb begin
        if (cmd.round_idx < T_F1) begin
            f_cur = (b_cur & c_cur) | (~b_cur & d_cur);
            k_cur = sha1s_pkg::K_0;
        end else if (cmd.round_idx < T_F2) begin
            f_cur = b_cur ^ c_cur ^ d_cur;
            k_cur = sha1s_pkg::K_1;
        end else if (cmd.round_idx < T_F3) begin
            f_cur = (b_cur & c_cur) | (b_cur & d_cur) | (c_cur & d_cur);
            k_cur = sha1s_pkg::K_2;
        end else begin
            f_cur = b_cur ^ c_cur ^ d_cur;
            k_cur = sha1s_pkg::K_3;
        end
        tmp_cur = {a_cur[26:0], a_cur[31:27]} + f_cur + e_cur + k_cur + w_cur;
    end

    // block buffer, byte lanes written big-endian
    always_ff @(posedge aclk) begin
        if (cmd.byte_wr) begin
            blk_word_reg[fill_reg[5:2]][lane_off +: 8] <= data_byte;
        end
    end

    // schedule window and working variables
    always_ff @(posedge aclk) begin
        if (cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_cur;
            var_reg[0]  <= tmp_cur;
            var_reg[1]  <= a_cur;
            var_reg[2]  <= {b_cur[1:0], b_cur[31:2]};
            var_reg[3]  <= c_cur;
            var_reg[4]  <= d_cur;
        end
    end

    // chaining words, fill position and bit counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg[0] <= sha1s_pkg::IV_H0;
            chain_reg[1] <= sha1s_pkg::IV_H1;
            chain_reg[2] <= sha1s_pkg::IV_H2;
            chain_reg[3] <= sha1s_pkg::IV_H3;
            chain_reg[4] <= sha1s_pkg::IV_H4;
            fill_reg     <= '0;
            bits_reg     <= '0;
        end else if (cmd.finish) begin
            chain_reg[0] <= sha1s_pkg::IV_H0;
            chain_reg[1] <= sha1s_pkg::IV_H1;
            chain_reg[2] <= sha1s_pkg::IV_H2;
            chain_reg[3] <= sha1s_pkg::IV_H3;
            chain_reg[4] <= sha1s_pkg::IV_H4;
            fill_reg     <= '0;
            bits_reg     <= '0;
        end else begin
            if (cmd.chain_add) begin
                for (int k = 0; k < 5; k++) begin
                    chain_reg[k] <= chain_reg[k] + var_reg[k];
                end
            end
            // fill wraps to zero when a block completes
            if (cmd.byte_wr) begin
                fill_reg <= fill_reg + 6'd1;
                bits_reg <= bits_reg + 64'd8;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg.digest_h0    <= chain_reg[0];
            out_reg.digest_h1    <= chain_reg[1];
            out_reg.digest_h2    <= chain_reg[2];
            out_reg.digest_h3    <= chain_reg[3];
            out_reg.digest_h4    <= chain_reg[4];
            out_reg.message_bits <= bits_reg;
        end
    end

endmodule

@@ rtl/sha1_stream_hash.sv @@
// top level of the byte-serial sha-1 stream hasher
// depends on sha1s_pkg, sha1s_ctrl and sha1s_dp
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | data_byte, byte_present, last
//   m_      | out | m_valid / m_ready  | digest_h0..digest_h4, message_bits
//
// a byte that does not complete a block leaves s_ready high
// a byte that completes a block holds s_ready low through the 80 rounds
// of the single round unit and then the chaining add
// a last item adds a padding choice, then one or two padding blocks, then
// the result load; that load waits while an earlier result stalls
// reset is synchronous and active low; the block is ready right after it
module sha1_stream_hash (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sha1s_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sha1s_pkg::out_item_t m_data
);

    sha1s_pkg::dp_cmd_t  cmd;
    sha1s_pkg::dp_stat_t stat;

    // sequencing
    sha1s_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // hashing datapath
    sha1s_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .data_byte (s_data.data_byte),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

@@ rtl/sha1s_checker.sv @@
// port-level checker of the sha-1 stream hasher, bound to the top level
// depends on sha1s_pkg and sha1_stream_hash_assert.svh
`include "sha1_stream_hash_assert.svh"

module sha1s_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input sha1s_pkg::in_item_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input sha1s_pkg::out_item_t m_data
);

    // a stalled result stays offered and unchanged
    `SHA1S_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")
    `SHA1S_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_data), "result changed while stalled")

    // closing a message always starts the padding work
    `SHA1S_ASSERT_NEXT(a_last_busy, s_valid && s_ready && s_data.last, !s_ready, "ready after last transfer")

    // lengths count whole bytes
    `SHA1S_ASSERT_NOW(a_len_bytes, m_valid, m_data.message_bits[2:0] == 3'd0, "bit count not byte aligned")

endmodule

bind sha1_stream_hash sha1s_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
